// ===== rtl/rab_pkg.sv =====
`default_nettype none

package rab_pkg;

   localparam int DEF_MAX_PATCHES = 64;
   localparam int DEF_MAX_WIDTH   = 1024;
   localparam int DEF_DEPTH_BITS  = 16;

   localparam int ROW_LIMIT   = 1024;
   localparam int ROW_BITS    = 10;
   localparam int LABEL_BITS  = 6;
   localparam int GEOM_BITS   = 11;
   localparam int PATCH_BITS  = 7;
   localparam int LIMIT_BITS  = 16;
   localparam int IN_DEPTH_BITS = 16;
   localparam int COUNT_BITS  = 13;
   localparam int MASK_BITS   = 64;
   localparam int NEIGHBORS   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_PATCH_COUNT  = 2'd2,
      REG_DEPTH_LIMIT  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [GEOM_BITS-1:0]  width;
      logic [GEOM_BITS-1:0]  height;
      logic [PATCH_BITS-1:0] patches;
      logic [LIMIT_BITS-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic                                  eof;
      logic [NEIGHBORS-1:0]                  near;
      logic [NEIGHBORS-1:0]                  touch;
      logic [NEIGHBORS-1:0][LABEL_BITS-1:0]  nb_lab;
      logic [LABEL_BITS-1:0]                 cur_lab;
   } link_type;

endpackage

`default_nettype wire

// ===== rtl/rab_csr.sv =====
`default_nettype none

module rab_csr import rab_pkg::*; #(
   parameter int MAX_PATCHES = DEF_MAX_PATCHES,
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output cfg_type          cfg
);

   logic [GEOM_BITS-1:0]  width_ff, width_in;
   logic [GEOM_BITS-1:0]  height_ff, height_in;
   logic [PATCH_BITS-1:0] patches_ff, patches_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic                  wr_en;
   reg_index_type         reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = reg_index_type'(paddr[3:2]);

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      patches_in = patches_ff;
      limit_in   = limit_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_FRAME_WIDTH:  width_in   = pwdata[GEOM_BITS-1:0];
            REG_FRAME_HEIGHT: height_in  = pwdata[GEOM_BITS-1:0];
            REG_PATCH_COUNT:  patches_in = pwdata[PATCH_BITS-1:0];
            REG_DEPTH_LIMIT:  limit_in   = pwdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= GEOM_BITS'(640);
         height_ff  <= GEOM_BITS'(480);
         patches_ff <= PATCH_BITS'(64);
         limit_ff   <= LIMIT_BITS'(20);
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         patches_ff <= patches_in;
         limit_ff   <= limit_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_FRAME_WIDTH:  prdata = 32'(width_ff);
         REG_FRAME_HEIGHT: prdata = 32'(height_ff);
         REG_PATCH_COUNT:  prdata = 32'(patches_ff);
         REG_DEPTH_LIMIT:  prdata = 32'(limit_ff);
         default:          prdata = '0;
      endcase
   end

   // clamp geometry and patch count to what the hardware holds
   always_comb begin
      cfg.limit = limit_ff;
      if (width_ff == '0) begin
         cfg.width = GEOM_BITS'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         cfg.width = GEOM_BITS'(MAX_WIDTH);
      end else begin
         cfg.width = width_ff;
      end
      if (height_ff == '0) begin
         cfg.height = GEOM_BITS'(1);
      end else if (int'(height_ff) > ROW_LIMIT) begin
         cfg.height = GEOM_BITS'(ROW_LIMIT);
      end else begin
         cfg.height = height_ff;
      end
      if (patches_ff == '0) begin
         cfg.patches = PATCH_BITS'(1);
      end else if (int'(patches_ff) > MAX_PATCHES) begin
         cfg.patches = PATCH_BITS'(MAX_PATCHES);
      end else begin
         cfg.patches = patches_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rab_front.sv =====
`default_nettype none

module rab_front import rab_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int DEPTH_BITS = DEF_DEPTH_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,
   input  wire logic        req_tuser,
   output link_type         link,
   output logic             link_valid,
   input  wire logic        link_full
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int PIX_BITS = 1 + LABEL_BITS + DEPTH_BITS;
   localparam int CMP_BITS = (DEPTH_BITS > LIMIT_BITS) ? DEPTH_BITS : LIMIT_BITS;
   localparam int V_POS    = PIX_BITS - 1;

   logic                  accept;
   logic                  fire;
   logic [LABEL_BITS-1:0] in_lab;
   logic [PIX_BITS-1:0]   in_pix;
   logic                  col_last;
   logic                  row_last;

   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [PIX_BITS-1:0]   s1_pix_ff;
   logic [COL_BITS-1:0]   s1_col_ff;
   logic                  s1_en_ff;
   logic                  s1_eof_ff;
   logic                  byp_ff, byp_in;
   logic [PIX_BITS-1:0]   byp_pix_ff;
   logic [PIX_BITS-1:0]   mem_rd_ff;
   logic [PIX_BITS-1:0]   left_ff, upleft_ff;
   logic [PIX_BITS-1:0]   up_pix;
   logic [PIX_BITS-1:0]   line_mem [MAX_WIDTH];

   logic [PIX_BITS-1:0]   nb_pix [NEIGHBORS];
   logic [DEPTH_BITS-1:0] cur_d, nb_d, diff;

   assign fire       = s1_valid_ff & ~link_full;
   assign req_tready = ~s1_valid_ff | ~link_full;
   assign accept     = req_tvalid & req_tready;

   assign in_lab = req_tdata[LABEL_BITS-1:0];
   assign in_pix = {req_tuser & (PATCH_BITS'(in_lab) < cfg.patches), in_lab,
                    DEPTH_BITS'(req_tdata[LABEL_BITS +: IN_DEPTH_BITS])};

   assign col_last = (COUNT_BITS'(col_ff) + COUNT_BITS'(1)) >= COUNT_BITS'(cfg.width);
   assign row_last = (GEOM_BITS'(row_ff) + GEOM_BITS'(1)) >= cfg.height;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = s1_valid_ff;
      byp_in      = byp_ff;
      if (fire) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         byp_in      = fire && (s1_col_ff == col_ff);
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
         left_ff     <= '0;
         upleft_ff   <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         byp_ff      <= byp_in;
         if (fire) begin
            left_ff   <= s1_pix_ff;
            upleft_ff <= up_pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= in_pix;
         s1_col_ff  <= col_ff;
         s1_en_ff   <= (row_ff != '0) && (col_ff != '0);
         s1_eof_ff  <= col_last & row_last;
         byp_pix_ff <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         line_mem[s1_col_ff] <= s1_pix_ff;
      end
      if (accept) begin
         mem_rd_ff <= line_mem[col_ff];
      end
   end

   assign up_pix = byp_ff ? byp_pix_ff : mem_rd_ff;

   always_comb begin
      nb_pix[0] = up_pix;
      nb_pix[1] = left_ff;
      nb_pix[2] = upleft_ff;
   end

   always_comb begin
      cur_d        = s1_pix_ff[DEPTH_BITS-1:0];
      nb_d         = '0;
      diff         = '0;
      link.eof     = s1_eof_ff;
      link.cur_lab = s1_pix_ff[DEPTH_BITS +: LABEL_BITS];
      for (int k = 0; k < NEIGHBORS; k++) begin
         nb_d           = nb_pix[k][DEPTH_BITS-1:0];
         diff           = (cur_d > nb_d) ? cur_d - nb_d : nb_d - cur_d;
         link.nb_lab[k] = nb_pix[k][DEPTH_BITS +: LABEL_BITS];
         link.touch[k]  = s1_en_ff & s1_pix_ff[V_POS] & nb_pix[k][V_POS] &
                          (link.nb_lab[k] != link.cur_lab);
         link.near[k]   = link.touch[k] &
                          (CMP_BITS'(diff) < CMP_BITS'(cfg.limit));
      end
   end

   assign link_valid = s1_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/rab_queue.sv =====
`default_nettype none

module rab_queue import rab_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire link_type push_data,
   output logic          full,
   input  wire logic     pop,
   output link_type      pop_data,
   output logic          empty
);

   link_type               store_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   push;
   logic                   take;

   assign full     = count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign push     = push_valid & ~full;
   assign take     = pop & ~empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push & ~take) begin
         count_in = count_ff + (QPTR_BITS+1)'(1);
      end else if (take & ~push) begin
         count_in = count_ff - (QPTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rab_back.sv =====
`default_nettype none

module rab_back import rab_pkg::*; #(
   parameter int MAX_PATCHES = DEF_MAX_PATCHES
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire link_type     rec,
   input  wire logic         rec_empty,
   output logic              rec_pop,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [135:0]      rsp_tdata,
   output logic              rsp_tlast
);

   typedef enum logic [1:0] {
      ST_APPLY = 2'b01,
      ST_DUMP  = 2'b10
   } state_type;

   localparam int P = MAX_PATCHES;

   state_type              state_ff, state_in;
   logic [LABEL_BITS-1:0]  cnt_ff, cnt_in;
   logic [P-1:0]           touch_ff [P];
   logic [P-1:0]           touch_in [P];
   logic [P-1:0]           depth_ff [P];
   logic [P-1:0]           depth_in [P];
   logic                   out_valid_ff, out_valid_in;
   logic [LABEL_BITS-1:0]  out_row_ff;
   logic [MASK_BITS-1:0]   out_touch_ff;
   logic [MASK_BITS-1:0]   out_depth_ff;
   logic                   out_last_ff;
   logic                   load;
   logic                   row_is_last;
   logic [P-1:0]           cur_oh;
   logic [P-1:0]           nb_oh [NEIGHBORS];
   logic [P-1:0]           tset, dset;

   assign rec_pop     = (state_ff == ST_APPLY) & ~rec_empty;
   assign load        = (state_ff == ST_DUMP) & (~out_valid_ff | rsp_tready);
   assign row_is_last = (PATCH_BITS'(cnt_ff) + PATCH_BITS'(1)) == cfg.patches;

   always_comb begin
      cur_oh = P'(1) << rec.cur_lab;
      for (int k = 0; k < NEIGHBORS; k++) begin
         nb_oh[k] = P'(1) << rec.nb_lab[k];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      tset         = '0;
      dset         = '0;
      for (int r = 0; r < P; r++) begin
         touch_in[r] = touch_ff[r];
         depth_in[r] = depth_ff[r];
      end
      unique case (state_ff)
         ST_APPLY: begin
            if (rec_pop) begin
               for (int r = 0; r < P; r++) begin
                  tset = '0;
                  dset = '0;
                  for (int k = 0; k < NEIGHBORS; k++) begin
                     if (rec.touch[k] && cur_oh[r]) tset = tset | nb_oh[k];
                     if (rec.touch[k] && nb_oh[k][r]) tset = tset | cur_oh;
                     if (rec.near[k] && cur_oh[r]) dset = dset | nb_oh[k];
                     if (rec.near[k] && nb_oh[k][r]) dset = dset | cur_oh;
                  end
                  touch_in[r] = touch_ff[r] | tset;
                  depth_in[r] = depth_ff[r] | dset;
               end
               if (rec.eof) begin
                  state_in = ST_DUMP;
                  cnt_in   = '0;
               end
            end
         end
         ST_DUMP: begin
            if (load) begin
               out_valid_in = 1'b1;
               // advance rows toward the output, clear everything after the last
               for (int r = 0; r < P - 1; r++) begin
                  touch_in[r] = row_is_last ? '0 : touch_ff[r+1];
                  depth_in[r] = row_is_last ? '0 : depth_ff[r+1];
               end
               touch_in[P-1] = '0;
               depth_in[P-1] = '0;
               if (row_is_last) begin
                  state_in = ST_APPLY;
               end else begin
                  cnt_in = cnt_ff + LABEL_BITS'(1);
               end
            end
         end
         default: state_in = ST_APPLY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_APPLY;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int r = 0; r < P; r++) begin
            touch_ff[r] <= '0;
            depth_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         for (int r = 0; r < P; r++) begin
            touch_ff[r] <= touch_in[r];
            depth_ff[r] <= depth_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_row_ff   <= cnt_ff;
         out_touch_ff <= MASK_BITS'(touch_ff[0]);
         out_depth_ff <= MASK_BITS'(depth_ff[0]);
         out_last_ff  <= row_is_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_depth_ff, out_touch_ff, out_row_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_last_row_matches_count: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |->
         ((PATCH_BITS'(out_row_ff) + PATCH_BITS'(1)) == cfg.patches))
      else $error("last row does not match patch count");

   a_depth_within_touch: assert property (@(posedge clock) disable iff (reset)
      (depth_ff[0] & ~touch_ff[0]) == '0)
      else $error("depth-touch bit without touch bit");

   a_cleared_after_dump: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == ST_DUMP) && state_ff == ST_APPLY) |->
         (touch_ff[0] == '0 && depth_ff[0] == '0 &&
          touch_ff[P-1] == '0 && depth_ff[P-1] == '0))
      else $error("matrices not cleared after readout");

   a_output_from_dump: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_DUMP))
      else $error("result raised outside readout");
`endif

endmodule

`default_nettype wire

// ===== rtl/region_adjacency_builder.sv =====
// Pixels: one per cycle while not stalled; each passes the front stage, 4-entry link queue and matrix update.
// Readout: starts once the matrix unit pops the frame's last link, then one row per cycle
// while rsp_tready allows, patch_count rows; the matrix unit takes no links during
// readout, so input stalls once the front stage and the queue are full.
// Reset: synchronous; counters, queue, adjacency matrices and registers return to reset
// values; the line buffer is not cleared.
`default_nettype none

module region_adjacency_builder import rab_pkg::*; #(
   parameter int MAX_PATCHES = DEF_MAX_PATCHES,
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int DEPTH_BITS  = DEF_DEPTH_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [23:0]  req_tdata,   // patch_label[5:0], depth[21:6], zero[23:22]
   input  wire logic         req_tuser,   // label_valid
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [135:0]      rsp_tdata,   // row_patch[5:0], touch_mask[69:6],
                                          // depth_touch_mask[133:70], zero[135:134]
   output logic              rsp_tlast,   // last_row
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [3:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic      [31:0]  prdata,
   output logic              pready
);

   cfg_type  cfg;
   link_type link;
   logic     link_valid;
   logic     link_full;
   link_type rec;
   logic     rec_empty;
   logic     rec_pop;

   rab_csr #(
      .MAX_PATCHES (MAX_PATCHES),
      .MAX_WIDTH   (MAX_WIDTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rab_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .link       (link),
      .link_valid (link_valid),
      .link_full  (link_full)
   );

   rab_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (link_valid),
      .push_data  (link),
      .full       (link_full),
      .pop        (rec_pop),
      .pop_data   (rec),
      .empty      (rec_empty)
   );

   rab_back #(
      .MAX_PATCHES (MAX_PATCHES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .rec        (rec),
      .rec_empty  (rec_empty),
      .rec_pop    (rec_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
